### rtl/svt_pkg.sv
// Shared types and codes for the sorted value table.
`default_nettype none
package svt_pkg;

    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int STORED_COUNT_W = 5;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [STATUS_W-1:0]       t_status;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Status codes
    localparam t_status STATUS_DONE      = 2'd0;
    localparam t_status STATUS_NOT_FOUND = 2'd1;
    localparam t_status STATUS_FULL      = 2'd2;

    // Operation broadcast to every cell
    typedef struct packed {
        logic   op;
        t_value value;
    } t_cmd;

    // What a cell shows its neighbors
    typedef struct packed {
        t_value value;
        logic   lt;     // occupied and stored value below the operand
    } t_link;

endpackage : svt_pkg
`default_nettype wire

### rtl/svt_cell.sv
// One slot of the ordered row: compare against the operand and shift left or right.
`default_nettype none
module svt_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  wire                 i_clk,
    input  wire                 i_update,
    input  svt_pkg::t_cmd       i_cmd,
    input  wire  [CNT_W-1:0]    i_count,
    input  svt_pkg::t_link      i_left,
    input  svt_pkg::t_value     i_right_value,
    input  wire                 i_hit_in,
    output svt_pkg::t_link      o_link,
    output logic                o_hit_out
);
    import svt_pkg::*;

    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

    t_value r_value;
    t_value n_value;
    logic   occupied;
    logic   lt;
    logic   eq;

    // Local compare against the broadcast operand
    assign occupied = MY_INDEX < i_count;
    assign lt       = occupied && (r_value < i_cmd.value);
    assign eq       = occupied && (r_value == i_cmd.value);

    // Match chain: set from the first equal copy onward
    assign o_hit_out = i_hit_in | eq;

    assign o_link.value = r_value;
    assign o_link.lt    = lt;

    // Insert: keep, take operand, or take left neighbor.
    // Remove: from the first match on, take right neighbor.
    always_comb begin
        n_value = r_value;
        if (i_cmd.op == OP_INSERT) begin
            if (lt) begin
                n_value = r_value;
            end else if (i_left.lt) begin
                n_value = i_cmd.value;
            end else begin
                n_value = i_left.value;
            end
        end else begin
            if (o_hit_out) begin
                n_value = i_right_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_update) begin
            r_value <= n_value;
        end
    end

endmodule : svt_cell
`default_nettype wire

### rtl/sorted_value_table.sv
// Top level of the sorted value table: cell row, entry count and result beat.
// Keeps up to CAPACITY signed 32-bit values in ascending order in a row of
// compare-and-shift cells. An input beat either inserts a value (ahead of the
// first stored value not smaller than it) or removes one stored copy. Each
// beat yields one result beat with status, count and the least and greatest
// values (both 0 when empty). The row updates in the cycle the beat is taken,
// the result is formed from the new row in the next cycle, and the block then
// holds off further input until the result beat is taken. The match chain
// through all cells and the last-entry select over the row set the critical
// paths. Values need no clearing after reset; only the entry count and the
// sequencer state are reset.
`default_nettype none
module sorted_value_table #(
    parameter int CAPACITY = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire                                   i_op,
    input  svt_pkg::t_value                       i_value,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output svt_pkg::t_status                      o_status,
    output logic [svt_pkg::STORED_COUNT_W-1:0]    o_stored_count,
    output svt_pkg::t_value                       o_smallest,
    output svt_pkg::t_value                       o_largest
);
    import svt_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WIDE_W = (CNT_W > STORED_COUNT_W) ? CNT_W : STORED_COUNT_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_status          r_status;
    t_status          n_status;
    t_value           r_smallest;
    t_value           r_largest;
    t_value           last_value;

    t_cmd             cmd;
    t_link            links [CAPACITY];
    logic             hits  [CAPACITY];
    logic             accept;
    logic             found;
    logic             full;
    logic             update;
    logic [WIDE_W-1:0] count_wide;

    assign cmd.op    = i_op;
    assign cmd.value = i_value;

    assign accept = i_in_valid && !o_in_stall;
    assign full   = (r_count == FULL_COUNT);
    assign found  = hits[CAPACITY-1];
    assign update = accept && ((i_op == OP_INSERT) ? !full : found);

    // Cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_link  left;
        t_value right_value;
        logic   hit_in;

        if (g == 0) begin : g_head
            assign left.value = i_value;
            assign left.lt    = 1'b1;
            assign hit_in     = 1'b0;
        end else begin : g_body
            assign left   = links[g-1];
            assign hit_in = hits[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_value = links[g].value;
        end else begin : g_inner
            assign right_value = links[g+1].value;
        end

        svt_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_update      (update),
            .i_cmd         (cmd),
            .i_count       (r_count),
            .i_left        (left),
            .i_right_value (right_value),
            .i_hit_in      (hit_in),
            .o_link        (links[g]),
            .o_hit_out     (hits[g])
        );
    end

    // Count and status at the accepted beat
    always_comb begin
        n_count  = r_count;
        n_status = r_status;
        if (accept) begin
            if (i_op == OP_INSERT) begin
                if (full) begin
                    n_status = STATUS_FULL;
                end else begin
                    n_status = STATUS_DONE;
                    n_count  = r_count + 1'b1;
                end
            end else begin
                if (found) begin
                    n_status = STATUS_DONE;
                    n_count  = r_count - 1'b1;
                end else begin
                    n_status = STATUS_NOT_FOUND;
                end
            end
        end
    end

    // Select the last occupied cell
    always_comb begin
        last_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (CNT_W'(k + 1) == r_count) begin
                last_value = last_value | links[k].value;
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: n_state = ST_SEND;
            ST_SEND: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (r_state == ST_CALC) begin
            if (r_count == '0) begin
                r_smallest <= '0;
                r_largest  <= '0;
            end else begin
                r_smallest <= links[0].value;
                r_largest  <= last_value;
            end
        end
    end

    assign count_wide     = WIDE_W'(r_count);
    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = (r_state == ST_SEND);
    assign o_status       = r_status;
    assign o_stored_count = count_wide[STORED_COUNT_W-1:0];
    assign o_smallest     = r_smallest;
    assign o_largest      = r_largest;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_op == OP_INSERT && !full |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the count");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_op == OP_INSERT && full |=> r_status == STATUS_FULL && $stable(r_count))
        else $error("insert into full table not refused");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_out_valid)
        else $error("result beat missing after accept");

endmodule : sorted_value_table
`default_nettype wire

### tb/tb_top.sv
// Testbench for the sorted value table: shadow table scoreboard, traffic tasks and top.
`timescale 1ns / 100ps

// One result beat as the table should report it
typedef struct {
    svt_pkg::t_status                      status;
    logic [svt_pkg::STORED_COUNT_W-1:0]    count;
    svt_pkg::t_value                       smallest;
    svt_pkg::t_value                       largest;
} t_table_report;

// Shadow copy of the ordered table plus the reports still owed by the block
class t_shadow_table;
    int                 capacity;
    svt_pkg::t_value    held[$];
    t_table_report      owed_reports[$];
    int                 mismatches;

    function new(int cap);
        capacity   = cap;
        mismatches = 0;
    endfunction

    // Apply one accepted input beat to the shadow table and queue its report
    function void apply_op(logic op, svt_pkg::t_value v);
        t_table_report r;
        int pos;
        pos = 0;
        if (op == svt_pkg::OP_INSERT) begin
            if (held.size() >= capacity) begin
                r.status = svt_pkg::STATUS_FULL;
            end else begin
                // lands ahead of the first entry not below v
                while (pos < held.size() && held[pos] < v) pos++;
                held.insert(pos, v);
                r.status = svt_pkg::STATUS_DONE;
            end
        end else begin
            while (pos < held.size() && held[pos] != v) pos++;
            if (pos >= held.size()) begin
                r.status = svt_pkg::STATUS_NOT_FOUND;
            end else begin
                held.delete(pos);
                r.status = svt_pkg::STATUS_DONE;
            end
        end
        r.count    = svt_pkg::STORED_COUNT_W'(held.size());
        r.smallest = (held.size() > 0) ? held[0] : '0;
        r.largest  = (held.size() > 0) ? held[$] : '0;
        owed_reports.push_back(r);
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Compare one accepted result beat against the oldest owed report
    task check_report(svt_pkg::t_status status, logic [svt_pkg::STORED_COUNT_W-1:0] count,
                      svt_pkg::t_value smallest, svt_pkg::t_value largest);
        t_table_report e;
        if (owed_reports.size() == 0) begin
            report_mismatch("result beat with no report owed");
            return;
        end
        e = owed_reports.pop_front();
        if (status !== e.status)
            report_mismatch($sformatf("status got %0d want %0d", status, e.status));
        if (count !== e.count)
            report_mismatch($sformatf("count got %0d want %0d", count, e.count));
        if (smallest !== e.smallest)
            report_mismatch($sformatf("smallest got %0d want %0d", smallest, e.smallest));
        if (largest !== e.largest)
            report_mismatch($sformatf("largest got %0d want %0d", largest, e.largest));
    endtask
endclass

module tb_top;
    import svt_pkg::*;

    localparam int     CAPACITY        = 16;
    localparam int     RANDOM_ITEMS    = 1500;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam t_value VAL_MIN         = 32'h8000_0000;
    localparam t_value VAL_MAX         = 32'h7fff_ffff;

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_in_valid  = 1'b0;
    logic    i_op        = OP_INSERT;
    t_value  i_value     = '0;
    logic    i_out_stall = 1'b0;
    logic    o_in_stall;
    logic    o_out_valid;
    t_status o_status;
    logic [STORED_COUNT_W-1:0] o_stored_count;
    t_value  o_smallest;
    t_value  o_largest;

    t_shadow_table sb;
    int  send_idle_pct = 33;
    int  recv_idle_pct = 54;
    bit  hold_req      = 1'b0;
    bit  fill_mode     = 1'b1;

    sorted_value_table #(.CAPACITY(CAPACITY)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_stored_count (o_stored_count),
        .o_smallest     (o_smallest),
        .o_largest      (o_largest)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Offer one beat after a random idle gap; return in the step it is taken
    task automatic send_item(logic op, t_value v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.apply_op(op, v);
    endtask

    // Extremes, empty remove, duplicates, absent remove, fill to full, refused insert
    task automatic run_directed();
        send_item(OP_REMOVE, -32'sd5);
        send_item(OP_INSERT, 32'sd0);
        send_item(OP_INSERT, VAL_MIN);
        send_item(OP_INSERT, VAL_MAX);
        send_item(OP_INSERT, -32'sd1);
        send_item(OP_INSERT, 32'sd0);
        send_item(OP_REMOVE, 32'sd0);
        send_item(OP_REMOVE, 32'sd12345);
        send_item(OP_REMOVE, VAL_MIN);
        send_item(OP_REMOVE, VAL_MAX);
        for (int k = 0; k < CAPACITY - 2; k++)
            send_item(OP_INSERT, t_value'(32'h1111_1111 * k - 32'h7777_7777));
        send_item(OP_INSERT, 32'sd42);
    endtask

    // Many small values for duplicates, some extremes, the rest full range
    function automatic t_value pick_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return t_value'(int'($urandom_range(8)) - 4);
            4: begin
                case ($urandom_range(3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return VAL_MIN + 1;
                    default: return VAL_MAX - 1;
                endcase
            end
            default: return t_value'($urandom);
        endcase
    endfunction

    // Alternate between filling and draining so full and empty cases recur
    task automatic run_random(int n);
        logic   op;
        t_value v;
        int     size;
        for (int k = 0; k < n; k++) begin
            size = sb.held.size();
            if (size == CAPACITY && fill_mode && $urandom_range(2) == 0)
                fill_mode = 1'b0;
            else if (size == 0 && !fill_mode && $urandom_range(2) == 0)
                fill_mode = 1'b1;
            if ($urandom_range(99) < 75)
                op = fill_mode ? OP_INSERT : OP_REMOVE;
            else
                op = fill_mode ? OP_REMOVE : OP_INSERT;
            if (op == OP_REMOVE && size > 0 && $urandom_range(99) < 70)
                v = sb.held[$urandom_range(size - 1)];
            else
                v = pick_value();
            send_item(op, v);
        end
    endtask

    // Result side: check taken beats, drive stall, run the long hold-off on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_report(o_status, o_stored_count, o_smallest, o_largest);
            if (hold_req) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Main sequence
    initial begin
        sb = new(CAPACITY);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random(RANDOM_ITEMS / 3);
        send_idle_pct = 54;
        recv_idle_pct = 33;
        run_random(RANDOM_ITEMS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        run_random(RANDOM_ITEMS / 3);
        i_in_valid <= 1'b0;
        while (sb.owed_reports.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### filelist.f
rtl/svt_pkg.sv
rtl/svt_cell.sv
rtl/sorted_value_table.sv
tb/tb_top.sv
